// ===== src/dcm_pkg.sv =====
// Shared types and constants for the diverging colormap pixel core.
package dcm_pkg;

  localparam int QUOT_BITS      = 8;   // quotient bits, one per divider cell
  localparam int DIV_EXTRA_BITS = 9;   // growth of the dividend from the x510 scale
  localparam int SCALE_SHIFT_HI = 9;   // 510 = 512 - 2
  localparam int SCALE_SHIFT_LO = 1;
  localparam int CFG_IDX_BITS   = 1;

  localparam logic [CFG_IDX_BITS-1:0] REG_LOW_LIMIT  = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HIGH_LIMIT = 1'd1;

  localparam logic [7:0] CHAN_FULL = 8'd255;
  localparam logic [7:0] CHAN_ZERO = 8'd0;

  typedef enum logic [1:0] {
    PK_SCALE,
    PK_MISSING,
    PK_RED,
    PK_BLUE
  } pix_kind_e;

  typedef struct packed {
    pix_kind_e            kind;
    logic                 lower;  // sample lies in the blue half of the scale
    logic [QUOT_BITS-1:0] quot;
  } side_t;

endpackage

// ===== src/dcm_in_if.sv =====
// Input channel: one signed sample per beat.
interface dcm_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// ===== src/dcm_out_if.sv =====
// Output channel: one RGB pixel and missing flag per beat.
interface dcm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       missing;

  modport source (output valid, output red, output green, output blue, output missing,
                  input ready);
  modport sink (input valid, input red, input green, input blue, input missing,
                output ready);
endinterface

// ===== src/diverging_colormap_pixel_core.sv =====
// Blue-white-red diverging colormap: one RGB pixel per signed sample.
// Pipeline: 3 front-end stages, 8 divider cells, 1 output register.
//   Every cell is a stage with its own valid bit.
// Throughput: one beat per cycle while the output does not stall.
// Reset: asynchronous, active low; clears all valid bits and loads the limits
//   with low -200 and high 200.
module diverging_colormap_pixel_core import dcm_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [SAMPLE_BITS-1:0]  cfg_wdata_i,
  dcm_in_if.sink                  in_if,
  dcm_out_if.source               out_if
);

  localparam int SB = SAMPLE_BITS;
  localparam int RW = SAMPLE_BITS + DIV_EXTRA_BITS;
  localparam logic signed [SB-1:0] LOW_RESET  = SB'(-200);
  localparam logic signed [SB-1:0] HIGH_RESET = SB'(200);

  logic signed [SB-1:0] low_q, high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= LOW_RESET;
      high_q <= HIGH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LOW_LIMIT:  low_q  <= cfg_wdata_i;
        REG_HIGH_LIMIT: high_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic          ch_v   [QUOT_BITS+1];
  logic          ch_rdy [QUOT_BITS+1];
  logic [RW-1:0] ch_rem [QUOT_BITS+1];
  logic [SB-1:0] ch_span[QUOT_BITS+1];
  side_t         ch_side[QUOT_BITS+1];

  dcm_prep #(.SAMPLE_BITS(SAMPLE_BITS)) u_prep (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .low_limit_i  (low_q),
    .high_limit_i (high_q),
    .up_valid_i   (in_if.valid),
    .up_ready_o   (in_if.ready),
    .up_sample_i  (in_if.sample),
    .dn_valid_o   (ch_v[0]),
    .dn_ready_i   (ch_rdy[0]),
    .dn_rem_o     (ch_rem[0]),
    .dn_span_o    (ch_span[0]),
    .dn_side_o    (ch_side[0])
  );

  // most significant quotient bit first
  for (genvar k = 0; k < QUOT_BITS; k++) begin : g_cell
    dcm_div_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .BIT_IDX     (QUOT_BITS - 1 - k)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .up_valid_i (ch_v[k]),
      .up_ready_o (ch_rdy[k]),
      .up_rem_i   (ch_rem[k]),
      .up_span_i  (ch_span[k]),
      .up_side_i  (ch_side[k]),
      .dn_valid_o (ch_v[k+1]),
      .dn_ready_i (ch_rdy[k+1]),
      .dn_rem_o   (ch_rem[k+1]),
      .dn_span_o  (ch_span[k+1]),
      .dn_side_o  (ch_side[k+1])
    );
  end

  // output register
  logic       out_v_q, out_load;
  logic [7:0] red_q, green_q, blue_q, red_d, green_d, blue_d;
  logic       miss_q, miss_d;
  side_t      last_side;

  assign last_side          = ch_side[QUOT_BITS];
  assign out_load           = !out_v_q || out_if.ready;
  assign ch_rdy[QUOT_BITS]  = out_load;

  always_comb begin
    red_d   = CHAN_ZERO;
    green_d = CHAN_ZERO;
    blue_d  = CHAN_ZERO;
    miss_d  = 1'b0;
    case (last_side.kind)
      PK_MISSING: miss_d = 1'b1;
      PK_RED:     red_d  = CHAN_FULL;
      PK_BLUE:    blue_d = CHAN_FULL;
      PK_SCALE: begin
        if (last_side.lower) begin
          red_d   = last_side.quot;
          green_d = last_side.quot;
          blue_d  = CHAN_FULL;
        end else begin
          red_d   = CHAN_FULL;
          green_d = last_side.quot;
          blue_d  = last_side.quot;
        end
      end
      default: miss_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_load) begin
      out_v_q <= ch_v[QUOT_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
      miss_q  <= miss_d;
    end
  end

  assign out_if.valid   = out_v_q;
  assign out_if.red     = red_q;
  assign out_if.green   = green_q;
  assign out_if.blue    = blue_q;
  assign out_if.missing = miss_q;

  // remainders of the last cell are not needed
  logic unused_rem;
  assign unused_rem = ^{ch_rem[QUOT_BITS], ch_span[QUOT_BITS]};

endmodule

// ===== src/dcm_prep.sv =====
// Front end: span and offset, classification, clamp and x510 dividend, three stages.
module dcm_prep import dcm_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic signed [SAMPLE_BITS-1:0]         low_limit_i,
  input  logic signed [SAMPLE_BITS-1:0]         high_limit_i,
  input  logic                                  up_valid_i,
  output logic                                  up_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]         up_sample_i,
  output logic                                  dn_valid_o,
  input  logic                                  dn_ready_i,
  output logic [SAMPLE_BITS+DIV_EXTRA_BITS-1:0] dn_rem_o,
  output logic [SAMPLE_BITS-1:0]                dn_span_o,
  output side_t                                 dn_side_o
);

  localparam int SB = SAMPLE_BITS;
  localparam int RW = SAMPLE_BITS + DIV_EXTRA_BITS;
  localparam logic signed [SB-1:0] FILL_VALUE = {1'b0, {(SB-1){1'b1}}};

  // stage A: differences
  logic                 a_v_q, a_load;
  logic signed [SB:0]   a_span_q, a_span_d;
  logic signed [SB:0]   a_num_q, a_num_d;
  logic                 a_miss_q, a_miss_d;
  // stage B: classification and clamp
  logic                 b_v_q, b_load;
  logic [SB-1:0]        b_x_q, b_x_d;
  logic [SB-1:0]        b_span_q, b_span_d;
  side_t                b_side_q, b_side_d;
  // stage C: dividend
  logic                 c_v_q, c_load;
  logic [RW-1:0]        c_rem_q, c_rem_d;
  logic [SB-1:0]        c_span_q;
  side_t                c_side_q;

  logic b_neg, b_over, b_half, b_span_pos, b_num_pos;

  assign c_load     = !c_v_q || dn_ready_i;
  assign b_load     = !b_v_q || c_load;
  assign a_load     = !a_v_q || b_load;
  assign up_ready_o = a_load;

  always_comb begin
    a_span_d = {high_limit_i[SB-1], high_limit_i} - {low_limit_i[SB-1], low_limit_i};
    a_num_d  = {up_sample_i[SB-1], up_sample_i} - {low_limit_i[SB-1], low_limit_i};
    a_miss_d = (up_sample_i == FILL_VALUE);
  end

  always_comb begin
    b_neg      = a_num_q[SB];
    b_over     = a_num_q > a_span_q;
    b_half     = $signed({a_num_q, 1'b0}) < $signed({a_span_q[SB], a_span_q});
    b_span_pos = !a_span_q[SB] && (a_span_q != '0);
    b_num_pos  = !a_num_q[SB] && (a_num_q != '0);
    b_span_d   = a_span_q[SB-1:0];
    b_side_d   = '{kind: PK_SCALE, lower: 1'b0, quot: '0};
    b_side_d.lower = b_neg || (!b_over && b_half);
    if (a_miss_q) begin
      b_side_d.kind = PK_MISSING;
    end else if (!b_span_pos) begin
      b_side_d.kind = b_num_pos ? PK_RED : PK_BLUE;
    end
    if (b_side_d.lower) begin
      b_x_d = b_neg ? '0 : a_num_q[SB-1:0];
    end else begin
      b_x_d = b_over ? '0 : (a_span_q[SB-1:0] - a_num_q[SB-1:0]);
    end
  end

  assign c_rem_d = (RW'(b_x_q) << SCALE_SHIFT_HI) - (RW'(b_x_q) << SCALE_SHIFT_LO);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else begin
      if (a_load) a_v_q <= up_valid_i;
      if (b_load) b_v_q <= a_v_q;
      if (c_load) c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_load) begin
      a_span_q <= a_span_d;
      a_num_q  <= a_num_d;
      a_miss_q <= a_miss_d;
    end
    if (b_load) begin
      b_x_q    <= b_x_d;
      b_span_q <= b_span_d;
      b_side_q <= b_side_d;
    end
    if (c_load) begin
      c_rem_q  <= c_rem_d;
      c_span_q <= b_span_q;
      c_side_q <= b_side_q;
    end
  end

  assign dn_valid_o = c_v_q;
  assign dn_rem_o   = c_rem_q;
  assign dn_span_o  = c_span_q;
  assign dn_side_o  = c_side_q;

endmodule

// ===== src/dcm_div_cell.sv =====
// One restoring-division cell: resolves a single quotient bit and passes the beat on.
module dcm_div_cell import dcm_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int BIT_IDX     = 0
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  up_valid_i,
  output logic                                  up_ready_o,
  input  logic [SAMPLE_BITS+DIV_EXTRA_BITS-1:0] up_rem_i,
  input  logic [SAMPLE_BITS-1:0]                up_span_i,
  input  side_t                                 up_side_i,
  output logic                                  dn_valid_o,
  input  logic                                  dn_ready_i,
  output logic [SAMPLE_BITS+DIV_EXTRA_BITS-1:0] dn_rem_o,
  output logic [SAMPLE_BITS-1:0]                dn_span_o,
  output side_t                                 dn_side_o
);

  localparam int RW = SAMPLE_BITS + DIV_EXTRA_BITS;

  logic                   v_q, load;
  logic [RW-1:0]          rem_q, rem_d, trial;
  logic [SAMPLE_BITS-1:0] span_q;
  side_t                  side_q, side_d;

  assign load       = !v_q || dn_ready_i;
  assign up_ready_o = load;

  always_comb begin
    trial  = RW'(up_span_i) << BIT_IDX;
    rem_d  = up_rem_i;
    side_d = up_side_i;
    if (up_rem_i >= trial) begin
      rem_d                = up_rem_i - trial;
      side_d.quot[BIT_IDX] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (load) begin
      v_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rem_q  <= rem_d;
      span_q <= up_span_i;
      side_q <= side_d;
    end
  end

  assign dn_valid_o = v_q;
  assign dn_rem_o   = rem_q;
  assign dn_span_o  = span_q;
  assign dn_side_o  = side_q;

endmodule

// ===== src/dcm_checker.sv =====
// Port-level checks for the colormap core, bound to the top level.
module dcm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] red_i,
  input logic [7:0] green_i,
  input logic [7:0] blue_i,
  input logic       missing_i
);

  a_missing_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && missing_i |-> red_i == 8'd0 && green_i == 8'd0 && blue_i == 8'd0)
    else $error("missing pixel is not black");

  a_end_channel_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !missing_i |-> red_i == 8'd255 || blue_i == 8'd255)
    else $error("pixel has neither red nor blue saturated");

  a_pair_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !missing_i |-> red_i == green_i || green_i == blue_i)
    else $error("pixel is off the blue-white-red scale");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable({red_i, green_i, blue_i, missing_i}))
    else $error("stalled output beat changed");

endmodule

bind diverging_colormap_pixel_core dcm_checker u_dcm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .red_i       (out_if.red),
  .green_i     (out_if.green),
  .blue_i      (out_if.blue),
  .missing_i   (out_if.missing)
);
